// ===== hw/rtl/kmce_pkg.sv =====
package kmce_pkg;

  localparam int COL_W      = 4;
  localparam int SAMPLE_W   = 8;
  localparam int ROW_IDX_W  = 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam int NUM_COLS_DEF = 16;
  localparam int NUM_ROWS_DEF = 8;

  typedef struct packed {
    logic                valid;
    logic [COL_W-1:0]    col;
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W-1:0] state;
  } kmce_load_t;

endpackage

// ===== hw/rtl/kmce_state_store.sv =====
module kmce_state_store
  import kmce_pkg::*;
#(
  parameter int NUM_COLS = NUM_COLS_DEF,
  parameter int NUM_ROWS = NUM_ROWS_DEF,
  localparam int IdxW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IdxW-1:0]     rd_idx,
  output logic [NUM_ROWS-1:0] rd_data,
  input  logic                wr_en,
  input  logic [IdxW-1:0]     wr_idx,
  input  logic [NUM_ROWS-1:0] wr_data
);

  logic [NUM_ROWS-1:0] state_r [NUM_COLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLS; i++) begin
        state_r[i] <= '0;
      end
    end else if (wr_en) begin
      state_r[wr_idx] <= wr_data;
    end
  end

  assign rd_data = state_r[rd_idx];

endmodule

// ===== hw/rtl/kmce_serialiser.sv =====
module kmce_serialiser
  import kmce_pkg::*;
#(
  parameter int NUM_ROWS = NUM_ROWS_DEF,
  localparam int RowW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kmce_load_t            load,
  output logic                  idle,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [NUM_ROWS-1:0] diff_r, diff_nxt;
  logic [NUM_ROWS-1:0] news_r, news_nxt;
  logic [RowW-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ROW_IDX_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic                out_press_r, out_press_nxt;
  logic                out_last_r, out_last_nxt;
  logic                advance;
  logic                emit;
  logic [NUM_ROWS-1:0] diff_shift;

  assign diff_shift = diff_r >> 1;
  assign advance    = (state_r == S_SCAN) && (!out_valid_r || out_tready);
  assign emit       = advance && diff_r[0];

  always_comb begin
    state_nxt     = state_r;
    diff_nxt      = diff_r;
    news_nxt      = news_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_press_nxt = out_press_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (load.valid) begin
          diff_nxt  = load.diff[NUM_ROWS-1:0];
          news_nxt  = load.state[NUM_ROWS-1:0];
          col_nxt   = load.col;
          row_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (advance) begin
          diff_nxt = diff_shift;
          news_nxt = news_r >> 1;
          row_nxt  = row_r + 1'b1;
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = ROW_IDX_W'(row_r);
            out_col_nxt   = col_r;
            out_press_nxt = news_r[0];
            out_last_nxt  = (diff_shift == '0);
          end
          if (diff_shift == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r      <= diff_nxt;
    news_r      <= news_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_press_r <= out_press_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign idle       = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_press_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (diff_r != '0))
    else $error("scan running with no changed rows left");

  a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |-> (state_r == S_IDLE))
    else $error("column loaded while a scan is running");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (diff_shift == '0)) |=> (state_r == S_IDLE) && out_valid_r && out_last_r)
    else $error("final event did not end the scan");
`endif

endmodule

// ===== hw/rtl/key_matrix_change_events_unit.sv =====
// Key matrix change-event unit.
// Input channel (in_*): one word per scanned column, carrying the column
// index and two active-low row reads. If both reads agree the inverted read
// becomes the column's key state; every row that changed gives one event.
// Output channel (out_*): one word per changed key, in ascending row order,
// with out_tlast high on the final event of the column. An unchanged column,
// disagreeing reads or a column at or above NUM_COLS give no events.
// Walk: the row bits are walked one per cycle by a shift register while the
// receiver does not stall, so a column with changes keeps in_tready low until
// its highest changed row has been walked. in_tready is high while no column
// is being walked; a column without changes leaves in_tready high.
// Stall: while an event is pending and out_tready is low the walk holds and the event stays.
// Reset: all keys read as released and both channels are emptied; no
// clearing pass is needed.
module key_matrix_change_events_unit
  import kmce_pkg::*;
#(
  parameter int NUM_COLS = NUM_COLS_DEF,
  parameter int NUM_ROWS = NUM_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // column_index, sample_first, sample_second
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // row_index, column_out, pressed
  output logic                  out_tlast   // last_event
);

  localparam int IdxW    = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
  localparam int ColExtW = ($clog2(NUM_COLS + 1) > COL_W) ? $clog2(NUM_COLS + 1) : COL_W;

  logic [COL_W-1:0]    column_index;
  logic [SAMPLE_W-1:0] sample_first;
  logic [SAMPLE_W-1:0] sample_second;
  logic [ColExtW-1:0]  col_ext;
  logic                in_range;
  logic                accept;
  logic [IdxW-1:0]     col_idx;
  logic [NUM_ROWS-1:0] old_state;
  logic [NUM_ROWS-1:0] new_state;
  logic [NUM_ROWS-1:0] diff;
  logic                idle;
  kmce_load_t          load;

  assign column_index  = in_tdata[COL_W-1:0];
  assign sample_first  = in_tdata[COL_W +: SAMPLE_W];
  assign sample_second = in_tdata[COL_W + SAMPLE_W +: SAMPLE_W];

  assign col_ext  = ColExtW'(column_index);
  assign in_range = (col_ext < ColExtW'(NUM_COLS));
  assign col_idx  = in_range ? col_ext[IdxW-1:0] : '0;
  assign accept   = in_tvalid && in_tready;

  assign new_state = (sample_first == sample_second) ? ~sample_first[NUM_ROWS-1:0] : old_state;
  assign diff      = new_state ^ old_state;

  assign load.valid = accept && in_range && (diff != '0);
  assign load.col   = column_index;
  assign load.diff  = SAMPLE_W'(diff);
  assign load.state = SAMPLE_W'(new_state);

  assign in_tready = idle;

  kmce_state_store #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (col_idx),
    .rd_data (old_state),
    .wr_en   (accept && in_range),
    .wr_idx  (col_idx),
    .wr_data (new_state)
  );

  kmce_serialiser #(
    .NUM_ROWS (NUM_ROWS)
  ) u_serialiser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .idle       (idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import kmce_pkg::*;

  localparam int ROWS = NUM_ROWS_DEF;
  localparam logic [SAMPLE_W-1:0] SENSE_BITS = 8'hFF >> (SAMPLE_W - ROWS);

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic [COL_W-1:0]     col;
    logic                 down;
    logic                 last;
  } key_event_t;

  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [SAMPLE_W-1:0] first;
    logic [SAMPLE_W-1:0] second;
    logic                typed;
    logic [SAMPLE_W-1:0] t_diff;
    logic [SAMPLE_W-1:0] t_state;
  } scan_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // column_index, sample_first, sample_second
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // row_index, column_out, pressed
  logic                  out_tlast;       // last_event

  key_event_t          events_due[$];
  logic [SAMPLE_W-1:0] key_mirror[NUM_COLS_DEF];
  int                  errors = 0;
  bit                  steady = 1'b0;
  int                  stall_left = 0;

  key_matrix_change_events_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [SAMPLE_W-1:0] settled_state(input logic [COL_W-1:0] col,
                                                       input logic [SAMPLE_W-1:0] first,
                                                       input logic [SAMPLE_W-1:0] second);
    if (first == second) return ~first & SENSE_BITS;
    return key_mirror[col];
  endfunction

  task automatic queue_changes(input logic [COL_W-1:0] col, input logic [SAMPLE_W-1:0] diff,
                               input logic [SAMPLE_W-1:0] state);
    int total;
    int seen;
    key_event_t ev;
    total = 0;
    seen = 0;
    for (int r = 0; r < ROWS; r++) total += diff[r];
    for (int r = 0; r < ROWS; r++) begin
      if (diff[r]) begin
        seen++;
        ev.row = r[ROW_IDX_W-1:0];
        ev.col = col;
        ev.down = state[r];
        ev.last = (seen == total);
        events_due.push_back(ev);
      end
    end
  endtask

  task automatic scan_column(input scan_row_t s);
    int gap;
    logic [SAMPLE_W-1:0] nxt;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, s.second, s.first, s.col};
    do @(posedge clk); while (!in_tready);
    nxt = settled_state(s.col, s.first, s.second);
    if (s.typed) queue_changes(s.col, s.t_diff, s.t_state);
    else queue_changes(s.col, nxt ^ key_mirror[s.col], nxt);
    key_mirror[s.col] = nxt;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (events_due.size() == 0) begin
        report_mismatch($sformatf("event with nothing due: %h last %b", out_tdata, out_tlast));
      end else begin
        key_event_t ev;
        ev = events_due.pop_front();
        if (out_tdata[2:0] != ev.row)
          report_mismatch($sformatf("row %0d, want %0d", out_tdata[2:0], ev.row));
        if (out_tdata[6:3] != ev.col)
          report_mismatch($sformatf("column %0d, want %0d", out_tdata[6:3], ev.col));
        if (out_tdata[7] != ev.down)
          report_mismatch($sformatf("pressed %b, want %b", out_tdata[7], ev.down));
        if (out_tlast != ev.last)
          report_mismatch($sformatf("last %b, want %b", out_tlast, ev.last));
      end
      stall_left = steady ? 0 : $urandom_range(0, 4);
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  scan_row_t directed[16] = '{
    '{4'd0,  8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00},
    '{4'd0,  8'h00, 8'h00, 1'b1, 8'hFF, 8'hFF},
    '{4'd0,  8'h00, 8'h00, 1'b1, 8'h00, 8'hFF},
    '{4'd0,  8'hFF, 8'hFF, 1'b1, 8'hFF, 8'h00},
    '{4'd15, 8'hFE, 8'hFE, 1'b1, 8'h01, 8'h01},
    '{4'd15, 8'h7F, 8'h7F, 1'b0, 8'h00, 8'h00},
    '{4'd15, 8'h00, 8'hFF, 1'b1, 8'h00, 8'h00},
    '{4'd15, 8'h55, 8'hAA, 1'b1, 8'h00, 8'h00},
    '{4'd7,  8'hAA, 8'hAA, 1'b0, 8'h00, 8'h00},
    '{4'd7,  8'h55, 8'h55, 1'b0, 8'h00, 8'h00},
    '{4'd8,  8'h0F, 8'h0F, 1'b0, 8'h00, 8'h00},
    '{4'd8,  8'hF0, 8'hF0, 1'b0, 8'h00, 8'h00},
    '{4'd1,  8'h00, 8'h01, 1'b1, 8'h00, 8'h00},
    '{4'd2,  8'h80, 8'h80, 1'b1, 8'h7F, 8'h7F},
    '{4'd3,  8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00},
    '{4'd15, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00}
  };

  initial begin
    scan_row_t s;
    logic [SAMPLE_W-1:0] flip;
    int pick;
    for (int c = 0; c < NUM_COLS_DEF; c++) key_mirror[c] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) scan_column(directed[i]);

    for (int n = 0; n < 200; n++) begin
      steady = (n >= 80 && n < 120);
      // hold until the matrix has drained
      if (n == 100) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (events_due.size() != 0);
      end
      s = '0;
      s.col = COL_W'($urandom_range(0, NUM_COLS_DEF - 1));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        flip = $urandom_range(0, 1) ? 8'($urandom & $urandom) : 8'h01 << $urandom_range(0, 7);
        if (pick == 0) flip = '0;
        s.first = ~(key_mirror[s.col] ^ flip);
        s.second = s.first;
      end else begin
        s.first = SAMPLE_W'($urandom);
        s.second = (pick == 9) ? s.first ^ (8'h01 << $urandom_range(0, 7)) : 8'($urandom);
      end
      scan_column(s);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (events_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
